@@ rtl/lzwd_pkg.sv @@
// Shared types and constants of the LZSS window decoder.
// No dependencies; imported by lzwd_ctrl, lzwd_dp and the top level.
package lzwd_pkg;

    localparam int unsigned IDX_BITS       = 12;
    localparam int unsigned LEN_BITS       = 4;
    localparam int unsigned BREAK_EVEN_DEF = 1;
    localparam int unsigned WIN_DEPTH      = 1 << IDX_BITS;

    typedef struct packed {
        logic                is_literal;
        logic [7:0]          literal_byte;
        logic [IDX_BITS-1:0] match_position;
        logic [LEN_BITS-1:0] length_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch_byte;
        logic start_copy;
        logic emit_literal;
        logic emit_end;
        logic emit_copy;
        logic clear_step;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic in_literal;
        logic in_end;
        logic slot_free;
        logic copy_last;
        logic clear_done;
    } stat_t;

endpackage

@@ rtl/lzwd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/lzwd_ctrl.sv @@
// Sequencing controller of the LZSS window decoder.
// Depends on lzwd_pkg (cmd_t, stat_t).
module lzwd_ctrl
    import lzwd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LIT,
        ST_END,
        ST_COPY
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    if (stat.in_literal) begin
                        cmd.latch_byte = 1'b1;
                        state_next     = ST_LIT;
                    end else if (stat.in_end) begin
                        state_next = ST_END;
                    end else begin
                        cmd.start_copy = 1'b1;
                        state_next     = ST_COPY;
                    end
                end
            end
            ST_LIT: begin
                if (stat.slot_free) begin
                    cmd.emit_literal = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_END: begin
                if (stat.slot_free) begin
                    cmd.emit_end = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            ST_COPY: begin
                if (stat.slot_free) begin
                    cmd.emit_copy = 1'b1;
                    if (stat.copy_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

endmodule

@@ rtl/lzwd_dp.sv @@
// Datapath of the LZSS window decoder: history window, pointers, output register.
// Depends on lzwd_pkg and lzwd_ram.
module lzwd_dp
    import lzwd_pkg::*;
#(
    parameter int unsigned BREAK_EVEN = BREAK_EVEN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  cmd_t      cmd,
    output stat_t     stat
);

    localparam int unsigned RunBits = $clog2((1 << LEN_BITS) + BREAK_EVEN + 1);

    logic [IDX_BITS-1:0] wpos_reg, src_reg, clr_cnt_reg;
    logic [RunBits-1:0]  rem_reg;
    logic [7:0]          lit_byte_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic                byp_reg;
    logic [7:0]          byp_data_reg;

    logic                wr_en, rd_en;
    logic [IDX_BITS-1:0] wr_addr, rd_addr;
    logic [7:0]          wr_data, ram_q, rd_byte;

    assign rd_byte = byp_reg ? byp_data_reg : ram_q;

    assign wr_en   = cmd.emit_literal | cmd.emit_copy | cmd.clear_step;
    assign wr_addr = cmd.clear_step ? clr_cnt_reg : wpos_reg;
    assign wr_data = cmd.clear_step   ? 8'd0 :
                     cmd.emit_literal ? lit_byte_reg : rd_byte;
    assign rd_en   = cmd.start_copy | cmd.emit_copy;
    assign rd_addr = cmd.start_copy ? s_data.match_position : src_reg;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Forward a byte written in the same cycle as its read (overlapping copy).
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_byte) begin
            lit_byte_reg <= s_data.literal_byte;
        end
        if (cmd.start_copy) begin
            src_reg <= s_data.match_position + IDX_BITS'(1);
            rem_reg <= RunBits'(s_data.length_code) + RunBits'(BREAK_EVEN + 1);
        end else if (cmd.emit_copy) begin
            src_reg <= src_reg + IDX_BITS'(1);
            rem_reg <= rem_reg - RunBits'(1);
        end
        if (cmd.emit_literal) begin
            m_data_reg <= '{data_byte: lit_byte_reg, run_last: 1'b1, stream_end: 1'b0};
        end else if (cmd.emit_copy) begin
            m_data_reg <= '{data_byte: rd_byte, run_last: (rem_reg == RunBits'(1)),
                            stream_end: 1'b0};
        end else if (cmd.emit_end) begin
            m_data_reg <= '{data_byte: 8'd0, run_last: 1'b1, stream_end: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg    <= IDX_BITS'(1);
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit_end) begin
                wpos_reg    <= IDX_BITS'(1);
                clr_cnt_reg <= '0;
            end else if (cmd.emit_literal || cmd.emit_copy) begin
                wpos_reg <= wpos_reg + IDX_BITS'(1);
            end else if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_BITS'(1);
            end
            if (cmd.emit_literal || cmd.emit_copy || cmd.emit_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.in_literal = s_data.is_literal;
    assign stat.in_end     = (s_data.match_position == '0);
    assign stat.slot_free  = !m_valid_reg || m_ready;
    assign stat.copy_last  = (rem_reg == RunBits'(1));
    assign stat.clear_done = (clr_cnt_reg == '1);

endmodule

@@ rtl/lzss_window_decoder_core.sv @@
// Top level of the LZSS window decoder: token in, decoded bytes out.
// Depends on lzwd_pkg, lzwd_ctrl, lzwd_dp (which holds lzwd_ram).
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  in_item_t  (one parsed token)
//  m_        out        m_valid / m_ready  out_item_t (one decoded byte)
//
// Tokens: a literal token is latched in ST_IDLE and emitted from ST_LIT; a match token
// starts its window read in ST_IDLE and emits its L-byte run (up to 17 at the default
// length field) from ST_COPY through the single read port of the history window, one
// byte read and one written per cycle while the output register is not stalled. An
// end-of-stream token is emitted from ST_END, then all 4096 window entries are cleared,
// one per cycle, before the next token is taken. Reset: synchronous, active low; the
// same clearing pass follows it. Stalls: a low m_ready holds the run in place; the
// next byte waits in the RAM read register until the output register frees up.
module lzss_window_decoder_core
    import lzwd_pkg::*;
#(
    parameter int unsigned BREAK_EVEN = BREAK_EVEN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequence tokens: one token in flight at a time.
    lzwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the window, the copy pointers and the output register.
    lzwd_dp #(
        .BREAK_EVEN (BREAK_EVEN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    // At most one window or output operation per cycle.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_literal, cmd.emit_copy, cmd.emit_end, cmd.clear_step}))
        else $error("conflicting datapath commands");

    // Drop ready right after a transaction: one token at a time.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("token accepted while another is in flight");

    // End-of-stream result closes the run and carries a zero byte.
    a_end_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stream_end) |-> (m_data.run_last && m_data.data_byte == 8'd0))
        else $error("malformed end-of-stream result");

    // After end of stream the window is being cleared: no token may enter.
    a_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_end |=> (!s_ready && cmd.clear_step))
        else $error("token window open during clearing pass");

endmodule
